// ===== sv/date_deque_with_search_unit_assert.svh =====
// Assertion macros for the date deque checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef DATE_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH
`define DATE_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication
`define DDQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DDQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ddq_pkg.sv =====
// Types and constants for the date deque with search.
// No dependencies.
package ddq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KIND_W    = 3;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int YEAR_W    = 14;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = 5;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_REM_FRONT  = 3'd2,
        K_REM_BACK   = 3'd3,
        K_PEEK_FRONT = 3'd4,
        K_PEEK_BACK  = 3'd5,
        K_SEARCH     = 3'd6
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_FIN
    } state_t;

    // month in the low bits, year in the high bits
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
    } date_t;

    typedef struct packed {
        status_t status;
        logic    found;
        date_t   date;
    } res_t;

endpackage

// ===== sv/ddq_if.sv =====
// Request and result channel interfaces for the date deque.
// Depends on ddq_pkg.
interface ddq_req_if;
    logic                          valid;
    logic                          ready;
    logic [ddq_pkg::KIND_W-1:0]    kind;
    logic [ddq_pkg::MONTH_W-1:0]   date_month;
    logic [ddq_pkg::DAY_W-1:0]     date_day;
    logic [ddq_pkg::YEAR_W-1:0]    date_year;

    modport source (output valid, kind, date_month, date_day, date_year, input ready);
    modport sink   (input valid, kind, date_month, date_day, date_year, output ready);
endinterface

interface ddq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ddq_pkg::STAT_W-1:0]    status;
    logic                          found;
    logic [ddq_pkg::MONTH_W-1:0]   out_month;
    logic [ddq_pkg::DAY_W-1:0]     out_day;
    logic [ddq_pkg::YEAR_W-1:0]    out_year;
    logic [ddq_pkg::CNT_W-1:0]     entry_count;

    modport source (output valid, status, found, out_month, out_day, out_year, entry_count,
                    input ready);
    modport sink   (input valid, status, found, out_month, out_day, out_year, entry_count,
                    output ready);
endinterface

// ===== sv/ddq_store.sv =====
// Entry store: one write port, one read port, registered read data.
// Depends on ddq_pkg.
module ddq_store #(
    parameter int DEPTH = ddq_pkg::DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  ddq_pkg::date_t           wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output ddq_pkg::date_t           rdata
);

    ddq_pkg::date_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/date_deque_with_search_unit.sv =====
// Date deque with search: top level, ring store plus sequencer.
// Depends on ddq_pkg, ddq_if, ddq_store.
//
//  channel | role | item
//  req     | sink | kind, date_month, date_day, date_year
//  rsp     | src  | status, found, out_month, out_day, out_year, entry_count
//
// Push or refused op: idle, finish. Remove/peek: idle, read, finish (one
// store read). Search: idle, scan, finish; one store read per cycle.
// Reset clears state, front, count, rsp.valid; store contents stay undefined.
// Result waits in an output register; a new item is taken meanwhile, but its
// result is not loaded until the output register is free.
module date_deque_with_search_unit #(
    parameter int DEPTH = ddq_pkg::DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ddq_req_if.sink    req,
    ddq_rsp_if.source  rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW:0]   DEPTH_W = (IW+1)'(DEPTH);
    localparam logic [IW-1:0] LAST    = IW'(DEPTH - 1);

    ddq_pkg::state_t  state_reg, state_next;
    logic [IW-1:0]    front_reg, front_next;
    logic [IW:0]      count_reg, count_next;
    logic [IW:0]      scan_reg, scan_next;
    ddq_pkg::kind_t   kind_reg, kind_next;
    ddq_pkg::date_t   key_reg, key_next;
    ddq_pkg::res_t    res_reg, res_next;

    logic                        rsp_valid_reg;
    ddq_pkg::res_t               out_res_reg;
    logic [ddq_pkg::CNT_W-1:0]   out_count_reg;

    logic            we;
    logic [IW-1:0]   waddr;
    logic [IW-1:0]   raddr;
    ddq_pkg::date_t  rd_data;
    ddq_pkg::date_t  in_date;
    ddq_pkg::kind_t  in_kind;
    logic            req_fire;
    logic            fin_load;
    logic            is_full;
    logic            is_empty;
    logic [IW-1:0]   front_dec;
    logic [IW:0]     scan_inc;
    logic [IW+ddq_pkg::CNT_W:0] count_ext;

    function automatic logic [IW-1:0] wrap_slot(input logic [IW:0] sum);
        logic [IW:0] w;
        w = (sum >= DEPTH_W) ? sum - DEPTH_W : sum;
        return w[IW-1:0];
    endfunction

    assign in_date   = '{year: req.date_year, day: req.date_day, month: req.date_month};
    assign in_kind   = ddq_pkg::kind_t'(req.kind);
    assign req.ready = (state_reg == ddq_pkg::S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign fin_load  = (state_reg == ddq_pkg::S_FIN) && (!rsp_valid_reg || rsp.ready);
    assign is_full   = (count_reg == DEPTH_W);
    assign is_empty  = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? LAST : front_reg - 1'b1;
    assign scan_inc  = scan_reg + 1'b1;
    assign count_ext = {{(ddq_pkg::CNT_W){1'b0}}, count_reg};

    ddq_store #(.DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (in_date),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ddq_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    case (in_kind) inside
                        ddq_pkg::K_REM_FRONT, ddq_pkg::K_REM_BACK,
                        ddq_pkg::K_PEEK_FRONT, ddq_pkg::K_PEEK_BACK:
                            state_next = is_empty ? ddq_pkg::S_FIN : ddq_pkg::S_READ;
                        ddq_pkg::K_SEARCH:
                            state_next = is_empty ? ddq_pkg::S_FIN : ddq_pkg::S_SCAN;
                        default:
                            state_next = ddq_pkg::S_FIN;
                    endcase
                end
            end
            ddq_pkg::S_READ:
                state_next = ddq_pkg::S_FIN;
            ddq_pkg::S_SCAN:
            begin
                if (rd_data == key_reg || scan_inc == count_reg)
                begin
                    state_next = ddq_pkg::S_FIN;
                end
            end
            ddq_pkg::S_FIN:
            begin
                if (fin_load)
                begin
                    state_next = ddq_pkg::S_IDLE;
                end
            end
            default:
                state_next = ddq_pkg::S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        kind_next  = kind_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        we         = 1'b0;
        waddr      = front_reg;
        raddr      = front_reg;
        unique case (state_reg)
            ddq_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    kind_next = in_kind;
                    key_next  = in_date;
                    res_next  = '{status: ddq_pkg::STAT_DONE, found: 1'b0, date: '0};
                    case (in_kind) inside
                        ddq_pkg::K_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                res_next.status = ddq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ddq_pkg::K_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                res_next.status = ddq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = wrap_slot({1'b0, front_reg} + count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ddq_pkg::K_REM_FRONT, ddq_pkg::K_PEEK_FRONT:
                        begin
                            if (is_empty)
                            begin
                                res_next.status = ddq_pkg::STAT_EMPTY;
                            end
                            raddr = front_reg;
                        end
                        ddq_pkg::K_REM_BACK, ddq_pkg::K_PEEK_BACK:
                        begin
                            if (is_empty)
                            begin
                                res_next.status = ddq_pkg::STAT_EMPTY;
                            end
                            raddr = wrap_slot({1'b0, front_reg} + count_reg - 1'b1);
                        end
                        ddq_pkg::K_SEARCH:
                        begin
                            raddr     = front_reg;
                            scan_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ddq_pkg::S_READ:
            begin
                res_next.date = rd_data;
                case (kind_reg)
                    ddq_pkg::K_REM_FRONT:
                    begin
                        front_next = wrap_slot({1'b0, front_reg} + 1'b1);
                        count_next = count_reg - 1'b1;
                    end
                    ddq_pkg::K_REM_BACK:
                        count_next = count_reg - 1'b1;
                    default:
                    begin
                    end
                endcase
            end
            ddq_pkg::S_SCAN:
            begin
                if (rd_data == key_reg)
                begin
                    res_next.found = 1'b1;
                end
                raddr     = wrap_slot({1'b0, front_reg} + scan_inc);
                scan_next = scan_inc;
            end
            ddq_pkg::S_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ddq_pkg::S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            if (fin_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        kind_reg <= kind_next;
        key_reg  <= key_next;
        res_reg  <= res_next;
        if (fin_load)
        begin
            out_res_reg   <= res_reg;
            out_count_reg <= count_ext[ddq_pkg::CNT_W-1:0];
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = out_res_reg.status;
    assign rsp.found       = out_res_reg.found;
    assign rsp.out_month   = out_res_reg.date.month;
    assign rsp.out_day     = out_res_reg.date.day;
    assign rsp.out_year    = out_res_reg.date.year;
    assign rsp.entry_count = out_count_reg;

endmodule

// ===== sv/ddq_checker.sv =====
// Port-level checks for the date deque, bound to the top level.
// Depends on ddq_pkg and date_deque_with_search_unit_assert.svh.
`include "date_deque_with_search_unit_assert.svh"

module ddq_checker #(
    parameter int DEPTH = ddq_pkg::DEPTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [ddq_pkg::STAT_W-1:0]    status,
    input logic                          found,
    input logic [ddq_pkg::MONTH_W-1:0]   out_month,
    input logic [ddq_pkg::DAY_W-1:0]     out_day,
    input logic [ddq_pkg::YEAR_W-1:0]    out_year,
    input logic [ddq_pkg::CNT_W-1:0]     entry_count
);

    localparam logic [ddq_pkg::CNT_W-1:0] FULL_CNT = ddq_pkg::CNT_W'(DEPTH);

    `DDQ_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(status) && $stable(entry_count), "result changed while stalled")
    `DDQ_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
        "second item taken while one is in work")
    `DDQ_ASSERT_IMP(a_full_count, rsp_valid && status == ddq_pkg::STAT_FULL,
        entry_count == FULL_CNT && !found, "full status with wrong count")
    `DDQ_ASSERT_IMP(a_empty_zero, rsp_valid && status == ddq_pkg::STAT_EMPTY,
        entry_count == '0 && !found && out_month == '0 && out_day == '0 && out_year == '0,
        "empty status with stale fields")

endmodule

bind date_deque_with_search_unit ddq_checker #(.DEPTH(DEPTH)) u_ddq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .found       (rsp.found),
    .out_month   (rsp.out_month),
    .out_day     (rsp.out_day),
    .out_year    (rsp.out_year),
    .entry_count (rsp.entry_count)
);
